[rtl/oal_pkg.sv]
// ============================================================================
// oal_pkg: shared definitions for the ordered array list
// Operation and status codes, field widths, parameter defaults and the
// control bundle that the list controller sends down the row of cells.
// ============================================================================
package oal_pkg;

    // Fixed widths of the request and result fields.
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Parameter defaults.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [FUNC_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Commands broadcast to every cell for the cycle of an accepted request.
    typedef struct packed {
        logic shift_up;    // insert: open a slot at the position
        logic shift_down;  // delete: close the slot at the position
        logic compare;     // find: capture the match flag
    } cell_ctl_t;

endpackage

[rtl/oal_cell.sv]
// ============================================================================
// oal_cell: one storage cell of the ordered array list
// Holds one entry, takes the entry of a neighbor when the list shifts, and
// captures whether its live entry equals the searched word.
// ============================================================================
module oal_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF,
    parameter int CMP_W      = oal_pkg::POS_W
) (
    input  logic                  aclk,
    input  oal_pkg::cell_ctl_t    ctl,
    input  logic [CMP_W-1:0]      pos,
    input  logic [CMP_W-1:0]      len,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_entry,
    input  logic [DATA_WIDTH-1:0] right_entry,
    output logic [DATA_WIDTH-1:0] entry,
    output logic                  hit
);
    import oal_pkg::*;

    localparam logic [CMP_W-1:0] IDX_C  = CMP_W'(IDX);
    localparam logic [CMP_W-1:0] IDX1_C = CMP_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  hit_reg;

    // The position is 1-based: this cell sits at position IDX + 1.
    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift_up) begin
            if (IDX_C >= pos) begin
                entry_next = left_entry;
            end else if (IDX1_C == pos) begin
                entry_next = word;
            end
        end else if (ctl.shift_down) begin
            if (IDX1_C >= pos) begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctl.compare) begin
            hit_reg <= (IDX_C < len) && (entry_reg == word);
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

[rtl/ordered_array_list.sv]
// ============================================================================
// ordered_array_list: fixed-capacity ordered list of words
// Find, insert at a 1-based position, and delete at a 1-based position,
// with one result per request.
// ============================================================================
// The list is a row of CAPACITY cells, one entry per cell. An insert or a
// delete moves every affected entry by one place in the cycle the request is
// accepted, each cell loading from its left or right neighbor. A find makes
// every cell compare its entry against the word in that same cycle and keep a
// match flag; a priority encoder then picks the lowest matching cell from the
// registered flags and the result is loaded into the output register. Every
// request, insert and delete included, passes through the match-flag
// register and the encode stage before its result is loaded, and no new
// request is taken until the encode stage has handed its result over. While
// the output register still holds an unaccepted result, the encode stage
// waits, and the input stays stalled until m_ready frees the register.
// The output register lets a new request be accepted while the previous
// result still waits on m_ready. Values are stored as their low DATA_WIDTH
// bits (zero-extended when DATA_WIDTH is wider than the value port). An
// insert into a full list is rejected with the full status before the
// position is checked; positions outside the list are rejected as illegal,
// and so is the unused operation code. The index field carries the low four
// bits of the first matching index for a successful find and zero otherwise;
// the count field carries the low five bits of the list length after the
// request. Entries hold no reset value and are never read before written.
// ============================================================================
module ordered_array_list #(
    parameter int CAPACITY   = oal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [oal_pkg::FUNC_W-1:0]    s_func,
    input  logic [oal_pkg::POS_W-1:0]     s_position,
    input  logic signed [oal_pkg::VALUE_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [oal_pkg::STATUS_W-1:0]  m_status,
    output logic [oal_pkg::INDEX_W-1:0]   m_index,
    output logic [oal_pkg::COUNT_W-1:0]   m_count
);
    import oal_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [LEN_W-1:0]    length_reg;
    logic [LEN_W-1:0]    length_next;
    logic                find_reg;
    logic [STATUS_W-1:0] req_status_reg;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                  accept;
    logic                  out_load;
    logic [DATA_WIDTH-1:0] word;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      len_c;
    logic [STATUS_W-1:0]   req_status;
    logic                  do_insert;
    logic                  do_delete;
    cell_ctl_t             cell_ctl;

    logic [DATA_WIDTH-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]   hit;
    logic [IDX_W-1:0]      first_idx;
    logic                  any_hit;
    logic [STATUS_W-1:0]   res_status;
    logic [INDEX_W-1:0]    res_index;

    // The value port is 32 bits and is taken as unsigned bits, so a wider
    // store sees it zero-extended.
    assign word   = DATA_WIDTH'($unsigned(s_value));
    assign pos_c  = CMP_W'(s_position);
    assign len_c  = CMP_W'(length_reg);

    // A request is taken only when the previous one has left the encode
    // stage; the output register decouples this side from m_ready.
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Request checks. The full test comes before the position test for an
    // insert, as a full list is reported as such whatever the position.
    always_comb begin
        req_status = ST_DONE;
        do_insert  = 1'b0;
        do_delete  = 1'b0;
        case (s_func)
            OP_FIND: begin
                req_status = ST_DONE;
            end
            OP_INSERT: begin
                if (length_reg == LEN_W'(CAPACITY)) begin
                    req_status = ST_FULL;
                end else if ((pos_c == '0) || (pos_c > CMP_W'(len_c + CMP_W'(1)))) begin
                    req_status = ST_ILLEGAL;
                end else begin
                    do_insert = 1'b1;
                end
            end
            OP_DELETE: begin
                if ((pos_c == '0) || (pos_c > len_c)) begin
                    req_status = ST_ILLEGAL;
                end else begin
                    do_delete = 1'b1;
                end
            end
            default: begin
                req_status = ST_ILLEGAL;
            end
        endcase
    end

    assign cell_ctl.shift_up   = accept && do_insert;
    assign cell_ctl.shift_down = accept && do_delete;
    assign cell_ctl.compare    = accept && (s_func == OP_FIND);

    always_comb begin
        length_next = length_reg;
        if (cell_ctl.shift_up) begin
            length_next = LEN_W'(length_reg + LEN_W'(1));
        end else if (cell_ctl.shift_down) begin
            length_next = LEN_W'(length_reg - LEN_W'(1));
        end
    end

    // The row of cells. The first cell has no left neighbor, and its stand-in
    // input is never selected; the last cell has no right neighbor and keeps its own entry on a delete.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_entry;
        logic [DATA_WIDTH-1:0] right_entry;

        if (i == 0) begin : g_first
            assign left_entry = word;
        end else begin : g_left
            assign left_entry = entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = entry[i];
        end else begin : g_right
            assign right_entry = entry[i+1];
        end

        oal_cell #(
            .IDX        (i),
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (cell_ctl),
            .pos         (pos_c),
            .len         (len_c),
            .word        (word),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry[i]),
            .hit         (hit[i])
        );
    end

    // Lowest matching cell wins. The match flags were registered in the
    // cycle of acceptance, so this encode has a register on either side.
    always_comb begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (hit[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit = |hit;

    always_comb begin
        res_status = req_status_reg;
        res_index  = '0;
        if (find_reg) begin
            if (any_hit) begin
                res_status = ST_DONE;
                res_index  = INDEX_W'(first_idx);
            end else begin
                res_status = ST_NOT_FOUND;
            end
        end
    end

    // The encode stage hands its result over once the output register is
    // free or being emptied in the same cycle.
    assign out_load = (state_reg == S_EVAL) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            length_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            length_reg  <= length_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            find_reg       <= (s_func == OP_FIND);
            req_status_reg <= req_status;
        end
        if (out_load) begin
            m_status_reg <= res_status;
            m_index_reg  <= res_index;
            m_count_reg  <= COUNT_W'(length_reg);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_index  = m_index_reg;
    assign m_count  = m_count_reg;

endmodule

[rtl/oal_checker.sv]
// ============================================================================
// oal_checker: port-level checks for the ordered array list
// Watches the request and result channels and flags results that the
// list could never give, then binds itself to the top level.
// ============================================================================
module oal_checker #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [oal_pkg::STATUS_W-1:0]  m_status,
    input logic [oal_pkg::INDEX_W-1:0]   m_index,
    input logic [oal_pkg::COUNT_W-1:0]   m_count
);
    import oal_pkg::*;

    // A result that waits on the consumer must not change.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_index)
            && $stable(m_count))
        else $error("result changed while stalled");

    // One request at a time: the cycle after an acceptance takes no request.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another was in flight");

    // Only a successful find reports an index.
    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_DONE) |-> m_index == '0)
        else $error("index set on a failed request");

    // A full list report comes with the count at capacity.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> m_count == COUNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    // The count never exceeds the capacity where the field can show it.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CAPACITY > 31) || (int'(m_count) <= CAPACITY))
        else $error("count above capacity");

endmodule

bind ordered_array_list oal_checker #(
    .CAPACITY (CAPACITY)
) u_oal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_index  (m_index),
    .m_count  (m_count)
);

[test/oal_result_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// oal_result_checker: result predictor and comparator for the ordered list
// Watches both channels of ordered_array_list, keeps its own copy of the
// list, predicts the result of every accepted request and compares each
// accepted result, field by field, with the oldest prediction.
// ============================================================================
module oal_result_checker #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [oal_pkg::FUNC_W-1:0]      s_func,
    input  logic [oal_pkg::POS_W-1:0]       s_position,
    input  logic [oal_pkg::VALUE_W-1:0]     s_value,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [oal_pkg::STATUS_W-1:0]    m_status,
    input  logic [oal_pkg::INDEX_W-1:0]     m_index,
    input  logic [oal_pkg::COUNT_W-1:0]     m_count,
    output int                              errors,
    output int                              pending,
    output int                              results_checked,
    output int                              finds_hit,
    output int                              full_refusals
);
    import oal_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   index;
        logic [COUNT_W-1:0]   count;
    } list_result_t;

    logic [VALUE_W-1:0] list_words [CAPACITY];
    int                 list_len;
    list_result_t       awaited_results [$];
    list_result_t       oldest;

    // Applies one request to the local copy of the list and returns its result.
    function automatic list_result_t list_apply(logic [FUNC_W-1:0] func,
                                                logic [POS_W-1:0] pos,
                                                logic [VALUE_W-1:0] word);
        list_result_t r;
        int           i;
        int           hit;
        r.status = ST_DONE;
        r.index  = '0;
        case (func)
            OP_FIND: begin
                hit = -1;
                for (i = 0; i < list_len; i++)
                    if (hit < 0 && list_words[i] == word)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r.index = hit[INDEX_W-1:0];
            end
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos < 1 || pos > list_len + 1) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    for (i = list_len; i >= pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos-1] = word;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    for (i = pos; i < list_len; i++)
                        list_words[i-1] = list_words[i];
                    list_len--;
                end
            end
            default: r.status = ST_ILLEGAL;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    initial begin
        errors          = 0;
        pending         = 0;
        results_checked = 0;
        finds_hit       = 0;
        full_refusals   = 0;
        list_len        = 0;
    end

    // A request is queued before the result of the same edge is checked, so
    // the oldest prediction is always the one the result belongs to.
    always @(posedge aclk) begin
        if (!aresetn) begin
            list_len = 0;
            awaited_results.delete();
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(list_apply(s_func, s_position, s_value));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no request outstanding: status %0d index %0d count %0d",
                                 $realtime, m_status, m_index, m_count);
                end else begin
                    oldest = awaited_results.pop_front();
                    results_checked++;
                    if (oldest.status == ST_DONE && m_status == ST_DONE && m_count == oldest.count
                        && oldest.index != 0)
                        finds_hit++;
                    if (oldest.status == ST_FULL)
                        full_refusals++;
                    if (m_status !== oldest.status || m_index !== oldest.index
                        || m_count !== oldest.count) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch: expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
                                     $realtime, oldest.status, oldest.index, oldest.count,
                                     m_status, m_index, m_count);
                    end
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

[test/tb_ordered_array_list.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_ordered_array_list: testbench for the ordered array list
// Drives find, insert and delete requests into the list, first a short
// directed sequence over the edge cases and then a long random sequence that
// walks the list between empty and full. A separate checker predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ============================================================================
module tb_ordered_array_list;
    import oal_pkg::*;

    // The unused operation code has no member in the package enum.
    localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_COUNT = 1800;
    localparam int PHASE_LEN    = 150;
    localparam int CAPACITY     = CAPACITY_DEF;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func;
    logic [POS_W-1:0]      s_position;
    logic [VALUE_W-1:0]    s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [INDEX_W-1:0]    m_index;
    logic [COUNT_W-1:0]    m_count;

    int errors;
    int pending;
    int results_checked;
    int finds_hit;
    int full_refusals;

    // Stimulus bookkeeping: how many requests went out, and how full the list
    // will be once all of them are done. The fill level only steers positions
    // toward legal ones; it plays no part in checking.
    int requests_sent;
    int fill;
    int idle_cycles;
    // When set, both sides run back to back with no idle cycles.
    logic no_idle;

    logic [VALUE_W-1:0] value_pool [8];

    ordered_array_list #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_position (s_position),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_index    (m_index),
        .m_count    (m_count)
    );

    oal_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_index         (m_index),
        .m_count         (m_count),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked),
        .finds_hit       (finds_hit),
        .full_refusals   (full_refusals)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Values are drawn mostly from a small pool so that finds often hit and
    // the list holds duplicates; the rest are full-range random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 70)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Offers one request. It is called at a falling edge and returns at the
    // falling edge after the request was accepted. Valid is only lowered when
    // a gap is drawn, so a back-to-back request keeps it high with a single
    // assignment in that time step.
    task automatic send_request(logic [FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= op;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        // Track the fill level the list will have after this request.
        if (op == OP_INSERT && fill < CAPACITY && pos >= 1 && pos <= fill + 1)
            fill++;
        else if (op == OP_DELETE && pos >= 1 && pos <= fill)
            fill--;
        @(negedge aclk);
    endtask

    // Result side: before each result the receiver draws a number of cycles
    // to hold m_ready low. Once in the run, well into the random part, it
    // holds off for a long stretch so the block backs up and stalls its input.
    initial begin
        int wait_cycles;
        int taken;
        m_ready = 1'b0;
        taken   = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (taken == 500)
                wait_cycles = 150;
            else if (no_idle)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 10);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
            @(negedge aclk);
        end
    end

    // Watchdog: ends the run when no request and no result has moved for
    // too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("tb_ordered_array_list: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int                 k;
        int                 n;
        int                 roll;
        int                 insert_share;
        logic [FUNC_W-1:0]  op;
        logic [POS_W-1:0]   pos;
        int                 share_by_phase [8];

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = OP_FIND;
        s_position    = '0;
        s_value       = '0;
        no_idle       = 1'b0;
        requests_sent = 0;
        fill          = 0;

        // The pool always holds the extreme words and zero.
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (k = 4; k < 8; k++)
            value_pool[k] = $urandom;

        // The insert share per random phase: some phases fill the list to
        // capacity, others drain it to empty, others hover in between.
        share_by_phase = '{90, 50, 10, 75, 25, 95, 60, 5};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. On the empty list: a find misses, a delete and two
        // inserts at bad positions are refused, and the unused operation code
        // is refused too.
        send_request(OP_FIND, 5'd0, 32'h0000_0000);
        send_request(OP_DELETE, 5'd31, 32'hffff_ffff);
        send_request(OP_INSERT, 5'd0, 32'h1234_5678);
        send_request(OP_INSERT, 5'd2, 32'h1234_5678);
        send_request(OP_UNUSED, 5'd31, 32'hffff_ffff);

        // Fill the list to capacity, inserting at the front, at the end and
        // in the middle in turn. The first words are the extremes; the rest
        // come from the pool so duplicates appear.
        for (k = 0; k < CAPACITY; k++) begin
            case (k % 3)
                0:       pos = 5'd1;
                1:       pos = POS_W'(k + 1);
                default: pos = POS_W'(k / 2 + 1);
            endcase
            send_request(OP_INSERT, pos, (k < 4) ? value_pool[k] : value_pool[k % 8]);
        end

        // A full list refuses an insert even when the position is also bad.
        send_request(OP_INSERT, 5'd0, 32'h0000_0001);
        // Finds over a full list, with duplicates present.
        send_request(OP_FIND, 5'd31, 32'hffff_ffff);
        send_request(OP_FIND, 5'd0, 32'h7fff_ffff);
        // Delete the last and then the first entry.
        send_request(OP_DELETE, POS_W'(CAPACITY), 32'h0000_0000);
        send_request(OP_DELETE, 5'd1, 32'h0000_0000);

        // Random part, in phases that shift the insert and delete balance.
        // Most requests are legal for the current fill level; a few are
        // unused codes or fully random noise.
        for (n = 0; n < RANDOM_COUNT; n++) begin
            if (n % PHASE_LEN == 0) begin
                insert_share = share_by_phase[(n / PHASE_LEN) % 8];
                no_idle      = ((n / PHASE_LEN) % 4 == 3);
            end
            // Once, the sender withdraws its offer and waits until every
            // result has come back.
            if (n == 1200 && pending != 0) begin
                s_valid <= 1'b0;
                while (pending != 0)
                    @(negedge aclk);
            end

            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op  = OP_UNUSED;
                pos = POS_W'($urandom_range(0, 31));
            end else if (roll < 7) begin
                op  = FUNC_W'($urandom_range(0, 2));
                pos = POS_W'($urandom_range(0, 31));
            end else if (roll < 30) begin
                op  = OP_FIND;
                pos = POS_W'($urandom_range(0, 31));
            end else if ($urandom_range(0, 99) < insert_share) begin
                op = OP_INSERT;
                if ($urandom_range(0, 4) == 0)
                    pos = $urandom_range(0, 1) ? POS_W'(1) : POS_W'(fill + 1);
                else
                    pos = POS_W'($urandom_range(1, fill + 1));
            end else begin
                op = OP_DELETE;
                if (fill == 0)
                    pos = POS_W'($urandom_range(0, 31));
                else if ($urandom_range(0, 4) == 0)
                    pos = $urandom_range(0, 1) ? POS_W'(1) : POS_W'(fill);
                else
                    pos = POS_W'($urandom_range(1, fill));
            end
            send_request(op, pos, pick_value());
        end
        s_valid <= 1'b0;

        // Drain every outstanding result, then let the pipeline settle.
        while (pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Sent %0d find, insert and delete requests and checked %0d results,",
                 requests_sent, results_checked);
        $display("with %0d finds past the head of the list and %0d inserts refused on a full list.",
                 finds_hit, full_refusals);
        if (errors == 0 && pending == 0)
            $display("tb_ordered_array_list: done, clean");
        else
            $display("tb_ordered_array_list: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/oal_pkg.sv
rtl/oal_cell.sv
rtl/ordered_array_list.sv
rtl/oal_checker.sv
test/oal_result_checker.sv
test/tb_ordered_array_list.sv
